// ===== rtl/core/dht_pkg.sv =====
// Shared types, constants and hash function of the double hashing table.
package dht_pkg;

  localparam int SLOT_BITS   = 10;
  localparam int TABLE_SLOTS = 1 << SLOT_BITS;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int HASH_MULT   = 31;

  localparam int IN_TDATA_BITS   = 64;
  localparam int OUT_TDATA_BITS  = 48;
  localparam int OUT_TUSER_BITS  = 2;
  localparam int SLOT_OUT_BITS   = 10;
  localparam int FOUND_BITS      = 32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef logic [SLOT_BITS-1:0]     slot_t;
  typedef logic [SLOT_BITS:0]       count_t;
  typedef logic [KEY_BITS-1:0]      key_t;
  typedef logic [VALUE_BITS-1:0]    value_t;
  typedef logic [FOUND_BITS-1:0]    found_t;
  typedef logic [SLOT_OUT_BITS-1:0] slot_out_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic   valid;
    key_t   key;
    value_t value;
  } slot_word_t;

  typedef struct packed {
    logic       we;
    slot_t      waddr;
    slot_word_t wdata;
    slot_t      raddr;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    status_t   status;
    found_t    found_value;
    slot_out_t slot_index;
  } result_t;

  // Probe stride: 31*key with 32-bit wrap, made odd.
  function automatic key_t step_hash(key_t k);
    key_t v;
    v = key_t'(k * key_t'(HASH_MULT));
    if (!v[0]) begin
      v = v - key_t'(1);
    end
    return v;
  endfunction

  // Reported slot number, taken modulo 1024.
  function automatic slot_out_t slot_out(slot_t s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_OUT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/dht_slot_store.sv =====
// Slot memory: valid flag, key and payload per slot, registered read.
module dht_slot_store (
  input  logic                  clk,
  input  dht_pkg::mem_req_t     req,
  output dht_pkg::slot_word_t   rd_data
);

  dht_pkg::slot_word_t mem [dht_pkg::TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

// ===== rtl/core/dht_probe_ctrl.sv =====
// Probe sequencer: clearing sweep, probe walk, read-modify-write of slots.
module dht_probe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  dht_pkg::key_t        in_key,
  input  dht_pkg::value_t      in_value,
  input  dht_pkg::slot_word_t  rd_data,
  output dht_pkg::mem_req_t    mem_req,
  output dht_pkg::result_t     res,
  input  logic                 res_ready
);

  dht_pkg::state_t   state, state_next;
  dht_pkg::slot_t    clr_idx;
  dht_pkg::count_t   count;
  logic              func;
  dht_pkg::key_t     key;
  dht_pkg::value_t   value;
  dht_pkg::key_t     h2;
  dht_pkg::key_t     pos;
  dht_pkg::slot_t    probe;

  dht_pkg::key_t     next_pos;
  dht_pkg::slot_t    cur_slot;
  logic              fin;
  logic              wr;
  logic              last_probe;
  dht_pkg::status_t  fin_status;
  dht_pkg::found_t   fin_value;
  dht_pkg::slot_out_t fin_slot;

  assign next_pos   = pos + h2;
  assign cur_slot   = pos[dht_pkg::SLOT_BITS-1:0];
  assign last_probe = (probe == '1);

  // Decide on the slot word just read for the current probe.
  always_comb begin
    fin        = 1'b0;
    wr         = 1'b0;
    fin_status = dht_pkg::ST_OK;
    fin_value  = '0;
    fin_slot   = '0;
    if (func == dht_pkg::FUNC_INSERT) begin
      if (count[dht_pkg::SLOT_BITS]) begin
        fin        = 1'b1;
        fin_status = dht_pkg::ST_FULL;
      end else if (!rd_data.valid) begin
        fin        = 1'b1;
        wr         = 1'b1;
        fin_slot   = dht_pkg::slot_out(cur_slot);
      end else if (last_probe) begin
        fin        = 1'b1;
        fin_status = dht_pkg::ST_FULL;
      end
    end else begin
      if (!rd_data.valid) begin
        fin        = 1'b1;
        fin_status = dht_pkg::ST_MISS;
      end else if (rd_data.key == key) begin
        fin        = 1'b1;
        fin_value  = dht_pkg::found_t'(rd_data.value);
        fin_slot   = dht_pkg::slot_out(cur_slot);
      end else if (last_probe) begin
        fin        = 1'b1;
        fin_status = dht_pkg::ST_MISS;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dht_pkg::S_CLEAR: begin
        if (clr_idx == '1) begin
          state_next = dht_pkg::S_IDLE;
        end
      end
      dht_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = dht_pkg::S_PROBE;
        end
      end
      dht_pkg::S_PROBE: begin
        if (fin && res_ready) begin
          state_next = dht_pkg::S_IDLE;
        end
      end
      default: state_next = dht_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready            = 1'b0;
    mem_req.we          = 1'b0;
    mem_req.waddr       = cur_slot;
    mem_req.wdata.valid = 1'b1;
    mem_req.wdata.key   = key;
    mem_req.wdata.value = value;
    mem_req.raddr       = cur_slot;
    res.valid           = 1'b0;
    res.status          = fin_status;
    res.found_value     = fin_value;
    res.slot_index      = fin_slot;
    case (state)
      dht_pkg::S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_idx;
        mem_req.wdata = '0;
      end
      dht_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        mem_req.raddr = in_key[dht_pkg::SLOT_BITS-1:0];
      end
      dht_pkg::S_PROBE: begin
        res.valid  = fin;
        mem_req.we = fin && res_ready && wr;
        // Re-read the current slot while stalled so the word stays valid.
        mem_req.raddr = fin ? cur_slot : next_pos[dht_pkg::SLOT_BITS-1:0];
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dht_pkg::S_CLEAR;
      clr_idx <= '0;
      count   <= '0;
    end else begin
      state <= state_next;
      if (state == dht_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + dht_pkg::slot_t'(1);
      end
      if (mem_req.we && state == dht_pkg::S_PROBE) begin
        count <= count + dht_pkg::count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dht_pkg::S_IDLE && in_valid) begin
      func  <= in_func;
      key   <= in_key;
      value <= in_value;
      h2    <= dht_pkg::step_hash(in_key);
      pos   <= in_key;
      probe <= '0;
    end else if (state == dht_pkg::S_PROBE && !fin) begin
      pos   <= next_pos;
      probe <= probe + dht_pkg::slot_t'(1);
    end
  end

endmodule

// ===== rtl/core/double_hash_table.sv =====
// Top level of the double hashing key/value table with its result register.
//
//  channel | dir | tdata (low bit up)               | tuser
//  --------+-----+----------------------------------+-------------
//  s_*     | in  | key[31:0], value[63:32]          | func[0]
//  m_*     | out | found_value[31:0], slot[41:32],  | status[1:0]
//          |     | zero pad[47:42]                  |
//
// The accept cycle issues the first slot read and each later cycle checks one
// slot word while reading the next, so the single read port of the slot memory
// sets the pace. An insert into a full table is rejected on its first probe.
// After reset a clearing pass zeroes every slot's valid flag; s_tready stays
// low meanwhile. The result register lets the next item in while a result
// waits on m_tready; a second finished result holds the walk until the
// register frees.
module double_hash_table (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [dht_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // key, value
  input  logic                                 s_tuser,   // func
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dht_pkg::OUT_TDATA_BITS-1:0]   m_tdata,   // found_value, slot_index, pad
  output logic [dht_pkg::OUT_TUSER_BITS-1:0]   m_tuser    // status
);

  dht_pkg::mem_req_t   mem_req;
  dht_pkg::slot_word_t rd_data;
  dht_pkg::result_t    res;
  logic                res_ready;

  // The result register can take a new result when empty or draining.
  assign res_ready = !m_tvalid || m_tready;

  dht_probe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_key    (s_tdata[dht_pkg::KEY_BITS-1:0]),
    .in_value  (dht_pkg::value_t'(s_tdata[dht_pkg::IN_TDATA_BITS-1:dht_pkg::KEY_BITS])),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .res       (res),
    .res_ready (res_ready)
  );

  dht_slot_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Hold the result until the transfer completes; advance on each new result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_tdata <= dht_pkg::OUT_TDATA_BITS'({res.slot_index, res.found_value});
      m_tuser <= res.status;
    end
  end

endmodule

// ===== rtl/core/dht_checker.sv =====
// Port-level checker for the double hashing table, bound to the top level.
module dht_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [dht_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  input logic [dht_pkg::OUT_TUSER_BITS-1:0]  m_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // One item at a time: an input transfer closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while probing");

  // A miss reports no payload and no slot.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dht_pkg::ST_MISS |-> m_tdata == '0)
    else $error("miss with nonzero data");

  // A rejected insert reports no payload and no slot.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dht_pkg::ST_FULL |-> m_tdata == '0)
    else $error("full status with nonzero data");

endmodule

bind double_hash_table dht_checker u_dht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the double hashing key/value table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dht_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int STALL_LIMIT    = 20000; // clearing pass, long hold-off, 1024-probe walks
  localparam int DRAIN_CYCLES   = 1100;  // longest single walk plus margin
  localparam int HOLDOFF_AT     = 1300;
  localparam int HOLDOFF_CYCLES = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int INSERT_PCT     = 65;    // enough inserts to fill the table late in the run

  typedef struct packed {
    status_t   status;
    found_t    found_value;
    slot_out_t slot_index;
  } reply_t;

  // Mirrors the table contents and holds the replies still owed by the block.
  class table_scoreboard;
    key_t   slot_key  [TABLE_SLOTS];
    value_t slot_val  [TABLE_SLOTS];
    bit     slot_used [TABLE_SLOTS];
    int     stored;
    reply_t replies_due[$];
    int     errors;

    function new();
      stored = 0;
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    // Walk the probe path (key + i*stride) mod size, as the block does.
    function reply_t table_op(logic func, key_t key, value_t value);
      reply_t r;
      key_t   stride;
      key_t   pos;
      slot_t  s;
      int     p;
      r.status      = ST_MISS;
      r.found_value = '0;
      r.slot_index  = '0;
      stride = key * key_t'(HASH_MULT);
      if (!stride[0]) stride = stride - key_t'(1);
      pos = key;
      if (func == FUNC_INSERT) begin
        r.status = ST_FULL;
        if (stored >= TABLE_SLOTS) return r;
        for (p = 0; p < TABLE_SLOTS; p++) begin
          s = pos[SLOT_BITS-1:0];
          if (!slot_used[s]) begin
            slot_used[s] = 1'b1;
            slot_key[s]  = key;
            slot_val[s]  = value;
            stored++;
            r.status     = ST_OK;
            r.slot_index = s;
            return r;
          end
          pos = pos + stride;
        end
        return r;
      end
      for (p = 0; p < TABLE_SLOTS; p++) begin
        s = pos[SLOT_BITS-1:0];
        if (!slot_used[s]) break;
        if (slot_key[s] == key) begin
          r.status      = ST_OK;
          r.found_value = slot_val[s];
          r.slot_index  = s;
          return r;
        end
        pos = pos + stride;
      end
      return r;
    endfunction

    function void accept_request(logic func, key_t key, value_t value);
      replies_due.push_back(table_op(func, key, value));
    endfunction

    function void check_reply(logic [1:0] status, found_t found, slot_out_t slot);
      reply_t want;
      if (replies_due.size() == 0) begin
        note_error($sformatf("unexpected reply: status %0d value %h slot %0d",
                             status, found, slot));
        return;
      end
      want = replies_due.pop_front();
      if (want.status !== status || want.found_value !== found ||
          want.slot_index !== slot)
        note_error($sformatf("expected status %0d value %h slot %0d, got status %0d value %h slot %0d",
                             int'(want.status), want.found_value, want.slot_index,
                             status, found, slot));
    endfunction

    function void close_out();
      if (replies_due.size() != 0)
        note_error($sformatf("%0d replies never arrived", replies_due.size()));
    endfunction
  endclass

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
  logic                      s_tuser  = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic [OUT_TUSER_BITS-1:0] m_tuser;

  table_scoreboard sb = new();
  key_t known_keys[$];
  int   tx_idle_pct     = 0;
  int   rx_idle_pct     = 0;
  int   accepted_inputs = 0;
  int   quiet_cycles    = 0;
  int   holdoff_left    = 0;
  bit   holdoff_done    = 1'b0;

  always #2 clk = ~clk;

  double_hash_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Offer one item, with random gaps ahead of it; return at the edge of its transfer.
  task automatic send_item(logic func, key_t key, value_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {value, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (func == FUNC_INSERT) known_keys.push_back(key);
  endtask

  // Random inserts and lookups: lookups mostly of stored keys, plus duplicates and keys sharing a home slot.
  task automatic send_random(int insert_pct);
    logic   func;
    key_t   key;
    key_t   old;
    value_t value;
    int     pick;
    func  = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_LOOKUP;
    value = $urandom();
    key   = $urandom();
    pick  = $urandom_range(9);
    if (known_keys.size() > 0) begin
      old = known_keys[$urandom_range(known_keys.size() - 1)];
      if ((func == FUNC_LOOKUP && pick < 8) || (func == FUNC_INSERT && pick inside {6, 7}))
        key = old;
      else if (pick >= 8)
        key = {key[KEY_BITS-1:SLOT_BITS], old[SLOT_BITS-1:0]};
    end
    send_item(func, key, value);
  endtask

  // Check each reply transfer, then log each request transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_reply(m_tuser, m_tdata[FOUND_BITS-1:0],
                       m_tdata[FOUND_BITS +: SLOT_OUT_BITS]);
      if (s_tvalid && s_tready) begin
        sb.accept_request(s_tuser, s_tdata[KEY_BITS-1:0], s_tdata[KEY_BITS +: VALUE_BITS]);
        accepted_inputs <= accepted_inputs + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (!holdoff_done && accepted_inputs >= HOLDOFF_AT) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_done = 1'b1;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 37;
    rx_idle_pct = 68;

    // Lookup in an empty table; the value field is ignored.
    send_item(FUNC_LOOKUP, 32'h0000_0000, 32'hDEAD_BEEF);
    // Key and value extremes.
    send_item(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(FUNC_INSERT, 32'h7FFF_FFFF, 32'h8000_0001);
    send_item(FUNC_INSERT, 32'hFFFF_FFFF, 32'h5555_AAAA);
    send_item(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    // Duplicate key: the lookup returns the first entry on the path.
    send_item(FUNC_INSERT, 32'h0000_0007, 32'h0000_0001);
    send_item(FUNC_INSERT, 32'h0000_0007, 32'h0000_0002);
    // Same home slot, different key.
    send_item(FUNC_INSERT, 32'h0000_0407, 32'h0000_0003);
    send_item(FUNC_LOOKUP, 32'h0000_0007, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h0000_0407, 32'h0000_0000);
    // Misses: the first walks past occupied slots, the second finds its home slot empty.
    send_item(FUNC_LOOKUP, 32'h0000_0807, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h7FFF_FFFE, 32'h0000_0000);

    // The table fills during the last phase, so full inserts and
    // full-length missing lookups come up there.
    repeat (600) send_random(INSERT_PCT);
    tx_idle_pct = 68;
    rx_idle_pct = 37;
    repeat (600) send_random(INSERT_PCT);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (700) send_random(INSERT_PCT);
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== double_hash_table.f =====
rtl/core/dht_pkg.sv
rtl/core/dht_slot_store.sv
rtl/core/dht_probe_ctrl.sv
rtl/core/double_hash_table.sv
rtl/core/dht_checker.sv
test/testbench.sv
